>>> rtl/core/smvm_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector multiply block.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package smvm_pkg;

    // Port field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 16;
    localparam int COUNT_W = 11;

    // Width that holds any column index or any column limit
    localparam int CMP_W = 17;

    // Defaults
    localparam int                 MAX_COLUMNS_DEF = 1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET     = 11'd1024;
    localparam int                 QUEUE_DEPTH     = 4;

    // Input item kinds; the fourth code carries no meaning
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // Operations passed from the front part to the back part
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_BAD,
        OP_END
    } op_t;

    localparam int OP_W = 2;

    // Queue status seen by its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/core/smvm_front.sv
// Front part: holds the column count register, accepts input items, classifies
// them and pushes operations into the queue. Depends on smvm_pkg.
`default_nettype none

module smvm_front #(
    parameter int MAX_COLUMNS = smvm_pkg::MAX_COLUMNS_DEF,
    parameter int ADDR_W      = $clog2(MAX_COLUMNS),
    parameter int ITEM_W      = smvm_pkg::OP_W + ADDR_W + smvm_pkg::VALUE_W
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [smvm_pkg::KIND_W-1:0]        kind,
    input  wire logic [smvm_pkg::INDEX_W-1:0]       index,
    input  wire logic signed [smvm_pkg::VALUE_W-1:0] value,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [smvm_pkg::COUNT_W-1:0]       column_count,
    input  wire smvm_pkg::queue_status_t            q_status,
    output logic                                    push,
    output logic [ITEM_W-1:0]                       push_item
);

    localparam logic [smvm_pkg::CMP_W-1:0] LIMIT = smvm_pkg::CMP_W'(MAX_COLUMNS);

    logic [smvm_pkg::COUNT_W-1:0] col_count_reg;
    logic [smvm_pkg::CMP_W-1:0]   idx_ext;
    logic [smvm_pkg::CMP_W-1:0]   count_ext;
    logic                         col_bad;
    logic                         keep;
    smvm_pkg::op_t                op;

    // Hold the column count; writes must arrive only while idle (not enforced)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= smvm_pkg::COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            col_count_reg <= column_count;
        end
    end

    // Check the column against the register and the store size
    assign idx_ext   = smvm_pkg::CMP_W'(index);
    assign count_ext = smvm_pkg::CMP_W'(col_count_reg);
    assign col_bad   = (idx_ext >= count_ext) || (idx_ext >= LIMIT);

    // Classify the item; drop loads beyond the store and the unused kind
    always_comb
    begin
        op   = smvm_pkg::OP_END;
        keep = 1'b0;
        case (kind)
            smvm_pkg::KIND_LOAD:
            begin
                op   = smvm_pkg::OP_LOAD;
                keep = (idx_ext < LIMIT);
            end
            smvm_pkg::KIND_NONZERO:
            begin
                op   = col_bad ? smvm_pkg::OP_BAD : smvm_pkg::OP_MAC;
                keep = 1'b1;
            end
            smvm_pkg::KIND_END:
            begin
                op   = smvm_pkg::OP_END;
                keep = 1'b1;
            end
            default:
            begin
                op   = smvm_pkg::OP_END;
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready  = !q_status.full;
    assign push      = in_valid && in_ready && keep;
    assign push_item = {op, idx_ext[ADDR_W-1:0], value};

endmodule

`default_nettype wire

>>> rtl/core/smvm_queue.sv
// Short queue between the front and back parts, flip-flop storage.
// Depends on smvm_pkg for the status struct.
`default_nettype none

module smvm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = smvm_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [WIDTH-1:0]     push_item,
    input  wire logic                 pop,
    output logic [WIDTH-1:0]          pop_item,
    output smvm_pkg::queue_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = slot_reg[rd_ptr_reg];

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/smvm_back.sv
// Back part: vector store, multiplier, saturating accumulator and result register.
// Pops operations from the queue in order. Depends on smvm_pkg.
`default_nettype none

module smvm_back #(
    parameter int MAX_COLUMNS = smvm_pkg::MAX_COLUMNS_DEF,
    parameter int ADDR_W      = $clog2(MAX_COLUMNS),
    parameter int ITEM_W      = smvm_pkg::OP_W + ADDR_W + smvm_pkg::VALUE_W
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire smvm_pkg::queue_status_t             q_status,
    input  wire logic [ITEM_W-1:0]                   pop_item,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [smvm_pkg::ROW_W-1:0]               row_number,
    output logic signed [smvm_pkg::VALUE_W-1:0]      row_sum,
    output logic                                     bad_column,
    output logic                                     saturated
);

    localparam int VW   = smvm_pkg::VALUE_W;
    localparam int PW   = 2 * VW;
    localparam int SW   = PW - 16 + 1;
    localparam logic signed [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

    logic signed [VW-1:0] store_mem [MAX_COLUMNS];

    logic [smvm_pkg::OP_W-1:0] q_op_bits;
    smvm_pkg::op_t        q_op;
    logic [ADDR_W-1:0]    q_addr;
    logic signed [VW-1:0] q_value;

    logic                 advance;
    logic                 s1_valid_reg;
    smvm_pkg::op_t        s1_op_reg;
    logic signed [VW-1:0] s1_val_reg;
    logic signed [VW-1:0] s1_vec_reg;
    logic                 s2_valid_reg;
    smvm_pkg::op_t        s2_op_reg;
    logic signed [PW-1:0] prod_reg;

    logic signed [VW-1:0]           acc_reg;
    logic                           err_reg;
    logic                           sat_reg;
    logic [smvm_pkg::ROW_W-1:0]     row_reg;
    logic signed [SW-1:0]           sum_wide;
    logic signed [VW-1:0]           sum_clamped;
    logic                           sum_over;
    logic                           sum_under;
    logic                           out_valid_reg;
    logic                           emit;

    assign {q_op_bits, q_addr, q_value} = pop_item;
    assign q_op = smvm_pkg::op_t'(q_op_bits);

    // Stall the whole back part only when a row end meets a full result register
    assign emit    = s2_valid_reg && (s2_op_reg == smvm_pkg::OP_END);
    assign advance = !(emit && out_valid_reg && !out_ready);
    assign pop     = advance && !q_status.empty;

    // Store port: write for loads, registered read for nonzeros
    always_ff @(posedge clk)
    begin
        if (pop && (q_op == smvm_pkg::OP_LOAD))
        begin
            store_mem[q_addr] <= q_value;
        end
        else if (pop)
        begin
            s1_vec_reg <= store_mem[q_addr];
        end
    end

    // Pipeline payload: operand, then product
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_val_reg <= q_value;
            s1_op_reg  <= q_op;
        end
        if (advance)
        begin
            prod_reg  <= s1_val_reg * s1_vec_reg;
            s2_op_reg <= s1_op_reg;
        end
    end

    // Pipeline valid bits; loads leave after the store write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pop && (q_op != smvm_pkg::OP_LOAD);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Add the floor-shifted product and clamp to 32 bits
    assign sum_wide    = SW'(acc_reg) + SW'($signed(prod_reg[PW-1:16]));
    assign sum_over    = !sum_wide[SW-1] && (sum_wide[SW-2:VW-1] != '0);
    assign sum_under   = sum_wide[SW-1] && (sum_wide[SW-2:VW-1] != '1);
    assign sum_clamped = sum_over ? SAT_MAX : (sum_under ? SAT_MIN : sum_wide[VW-1:0]);

    // Accumulate, flag, and close rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && s2_valid_reg)
            begin
                case (s2_op_reg)
                    smvm_pkg::OP_MAC:
                    begin
                        acc_reg <= sum_clamped;
                        if (sum_over || sum_under)
                        begin
                            sat_reg <= 1'b1;
                        end
                    end
                    smvm_pkg::OP_BAD:
                    begin
                        err_reg <= 1'b1;
                    end
                    smvm_pkg::OP_END:
                    begin
                        acc_reg       <= '0;
                        err_reg       <= 1'b0;
                        sat_reg       <= 1'b0;
                        row_reg       <= row_reg + 1'b1;
                    end
                    default:
                    begin
                        acc_reg <= acc_reg;
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            row_number <= row_reg;
            row_sum    <= acc_reg;
            bad_column <= err_reg;
            saturated  <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/sparse_matrix_vector_multiply_csr_top.sv
// Top level of the CSR sparse matrix-vector multiply block.
// Instantiates smvm_front, smvm_queue and smvm_back; depends on smvm_pkg.
//
//  Channel   Handshake               Payload
//  input     in_valid / in_ready     kind, index, value
//  result    out_valid / out_ready   row_number, row_sum, bad_column, saturated
//  config    cfg_valid / cfg_ready   column_count
//
// One item per cycle is accepted while the queue has room; the multiply and the
// accumulate each take one stage, so nonzeros sustain one per cycle unless the
// back part stalls. A row end's result is registered after the product stage.
// Reset clears control state and the accumulator; the vector store is not cleared.
// A result held by out_ready low stops the back part once the next row end reaches
// the accumulate stage; the four-entry queue then absorbs items until it fills,
// then in_ready drops.
`default_nettype none

module sparse_matrix_vector_multiply_csr_top #(
    parameter int MAX_COLUMNS = smvm_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [smvm_pkg::KIND_W-1:0]         kind,
    input  wire logic [smvm_pkg::INDEX_W-1:0]        index,
    input  wire logic signed [smvm_pkg::VALUE_W-1:0] value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [smvm_pkg::ROW_W-1:0]               row_number,
    output logic signed [smvm_pkg::VALUE_W-1:0]      row_sum,
    output logic                                     bad_column,
    output logic                                     saturated,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [smvm_pkg::COUNT_W-1:0]        column_count
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int ITEM_W = smvm_pkg::OP_W + ADDR_W + smvm_pkg::VALUE_W;

    smvm_pkg::queue_status_t q_status;
    logic                    push;
    logic [ITEM_W-1:0]       push_item;
    logic                    pop;
    logic [ITEM_W-1:0]       pop_item;

    smvm_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .index        (index),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .column_count (column_count),
        .q_status     (q_status),
        .push         (push),
        .push_item    (push_item)
    );

    smvm_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (smvm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    smvm_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .row_number (row_number),
        .row_sum    (row_sum),
        .bad_column (bad_column),
        .saturated  (saturated)
    );

endmodule

`default_nettype wire

>>> rtl/core/smvm_checker.sv
// Port-level checks for the CSR sparse matrix-vector multiply top level,
// attached by bind. Depends on smvm_pkg.
`default_nettype none

module smvm_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [smvm_pkg::KIND_W-1:0]         kind,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [smvm_pkg::ROW_W-1:0]          row_number,
    input wire logic signed [smvm_pkg::VALUE_W-1:0] row_sum
);

    logic [smvm_pkg::ROW_W-1:0] expect_row_reg;
    logic [16:0]                pending_reg;
    logic                       end_in;
    logic                       res_out;

    assign end_in  = in_valid && in_ready && (kind == smvm_pkg::KIND_END);
    assign res_out = out_valid && out_ready;

    // Track row ends taken in and results handed out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_row_reg <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            if (res_out)
            begin
                expect_row_reg <= expect_row_reg + 1'b1;
            end
            if (end_in && !res_out)
            begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (res_out && !end_in)
            begin
                pending_reg <= pending_reg - 1'b1;
            end
        end
    end

    a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("result shown with no row end outstanding");

    a_row_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row_number == expect_row_reg))
        else $error("row number out of sequence");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_sum) && $stable(row_number))
        else $error("stalled result changed");

endmodule

bind sparse_matrix_vector_multiply_csr_top smvm_checker u_smvm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .row_number (row_number),
    .row_sum    (row_sum)
);

`default_nettype wire
